// ----- rtl/sli_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sli_pkg: shared definitions for the source line index
// Request codes, result kinds, lookup states and defaults used by the
// line index top level and its lookup engine.
// ---------------------------------------------------------------------------
package sli_pkg;

    localparam int MAX_LINES_DEF   = 1024;
    localparam int OFFSET_BITS_DEF = 20;

    localparam int BYTE_BITS       = 8;
    localparam int QUERY_LINE_BITS = 12;
    localparam int REQ_BITS        = 2;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_START  = 2'd0,
        REQ_BYTE   = 2'd1,
        REQ_OFFSET = 2'd2,
        REQ_LINE   = 2'd3
    } req_t;

    localparam logic [BYTE_BITS-1:0] NL_BYTE = 8'h0A;
    localparam logic [BYTE_BITS-1:0] CR_BYTE = 8'h0D;

    localparam logic KIND_POS  = 1'b0;
    localparam logic KIND_LINE = 1'b1;

    typedef enum logic [2:0] {
        LK_IDLE,
        LK_SRCH_RD,
        LK_SRCH_CMP,
        LK_LINE_RD_START,
        LK_LINE_RD_NEXT,
        LK_LINE_CALC,
        LK_RESULT
    } lk_state_t;

    // Query command from the input side to the lookup engine
    typedef struct packed {
        logic go;
        logic is_line;
    } lk_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/sli_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sli_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module sli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ----- rtl/sli_lookup.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sli_lookup: query engine of the line index
// Binary-searches the line start RAM for offset queries, fetches line
// extents for line queries, and holds each answer in the output register.
// ---------------------------------------------------------------------------
module sli_lookup #(
    parameter int MAX_LINES   = sli_pkg::MAX_LINES_DEF,
    parameter int OFFSET_BITS = sli_pkg::OFFSET_BITS_DEF,
    localparam int ADDR_BITS  = $clog2(MAX_LINES),
    localparam int LINE_BITS  = $clog2(MAX_LINES + 1),
    localparam int ENTRY_W    = OFFSET_BITS + 1,
    localparam int OUT_FIELDS = LINE_BITS + 3 * OFFSET_BITS + 3,
    localparam int OUT_W      = ((OUT_FIELDS + 7) / 8) * 8
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire sli_pkg::lk_cmd_t                    cmd,
    input  wire logic [OFFSET_BITS-1:0]              query_offset,
    input  wire logic [sli_pkg::QUERY_LINE_BITS-1:0] query_line,
    input  wire logic [LINE_BITS-1:0]                line_total,
    input  wire logic [OFFSET_BITS-1:0]              text_length,
    input  wire logic                                prev_cr,
    input  wire logic                                overflow,
    output logic                                     busy,
    output logic      [ADDR_BITS-1:0]                rd_addr,
    input  wire logic [ENTRY_W-1:0]                  rd_data,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [OUT_W-1:0]                    m_tdata,
    output logic                                     m_tuser
);

    localparam int CMP_W = (LINE_BITS > sli_pkg::QUERY_LINE_BITS) ?
                           LINE_BITS : sli_pkg::QUERY_LINE_BITS;

    sli_pkg::lk_state_t state_reg, state_next;

    logic [LINE_BITS-1:0]   lo_reg, lo_next;
    logic [LINE_BITS-1:0]   hi_reg, hi_next;
    logic [ADDR_BITS-1:0]   mid_reg, mid_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [CMP_W-1:0]       line_reg, line_next;
    logic [OFFSET_BITS-1:0] best_reg, best_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [OFFSET_BITS-1:0] len_reg, len_next;
    logic                   kind_reg, kind_next;
    logic                   found_reg, found_next;
    logic                   has_next_reg, has_next_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]       m_tdata_reg, m_tdata_next;
    logic                   m_tuser_reg, m_tuser_next;

    logic [CMP_W-1:0]       q_line_ext;
    logic [CMP_W-1:0]       total_ext;
    logic                   line_ok;
    logic                   line_has_next;
    logic [LINE_BITS:0]     lohi_sum;
    logic [LINE_BITS-1:0]   mid_full;
    logic [CMP_W-1:0]       line_m1;
    logic [OFFSET_BITS-1:0] ram_start;
    logic [OFFSET_BITS-1:0] end_off;
    logic                   end_cr;
    logic [OFFSET_BITS:0]   column;
    logic                   out_free;

    assign q_line_ext    = CMP_W'(query_line);
    assign total_ext     = CMP_W'(line_total);
    assign line_ok       = (q_line_ext != '0) && (q_line_ext <= total_ext);
    assign line_has_next = q_line_ext < total_ext;
    assign lohi_sum      = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_full      = lohi_sum[LINE_BITS:1];
    assign line_m1       = line_reg - CMP_W'(1);
    assign ram_start     = rd_data[OFFSET_BITS-1:0];
    assign out_free      = !m_tvalid_reg || m_tready;

    // Line end: byte before the next line start, or the source end for the last line
    always_comb begin
        if (has_next_reg) begin
            end_off = (ram_start != '0) ? ram_start - OFFSET_BITS'(1) : '0;
            end_cr  = rd_data[OFFSET_BITS];
        end else begin
            end_off = text_length;
            end_cr  = prev_cr;
        end
    end

    assign column = (lo_reg == '0) ? (OFFSET_BITS + 1)'(1) :
                    ({1'b0, offset_reg} - {1'b0, best_reg} + (OFFSET_BITS + 1)'(1));

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sli_pkg::LK_IDLE: begin
                if (cmd.go) begin
                    if (!cmd.is_line) begin
                        state_next = sli_pkg::LK_SRCH_RD;
                    end else if (line_ok) begin
                        state_next = sli_pkg::LK_LINE_RD_START;
                    end else begin
                        state_next = sli_pkg::LK_RESULT;
                    end
                end
            end
            sli_pkg::LK_SRCH_RD: begin
                state_next = (lo_reg < hi_reg) ? sli_pkg::LK_SRCH_CMP : sli_pkg::LK_RESULT;
            end
            sli_pkg::LK_SRCH_CMP:      state_next = sli_pkg::LK_SRCH_RD;
            sli_pkg::LK_LINE_RD_START: state_next = sli_pkg::LK_LINE_RD_NEXT;
            sli_pkg::LK_LINE_RD_NEXT:  state_next = sli_pkg::LK_LINE_CALC;
            sli_pkg::LK_LINE_CALC:     state_next = sli_pkg::LK_RESULT;
            sli_pkg::LK_RESULT: begin
                if (out_free) begin
                    state_next = sli_pkg::LK_IDLE;
                end
            end
            default: state_next = sli_pkg::LK_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        offset_next   = offset_reg;
        line_next     = line_reg;
        best_next     = best_reg;
        start_next    = start_reg;
        len_next      = len_reg;
        kind_next     = kind_reg;
        found_next    = found_reg;
        has_next_next = has_next_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        rd_addr       = '0;
        case (state_reg)
            sli_pkg::LK_IDLE: begin
                if (cmd.go) begin
                    offset_next   = query_offset;
                    line_next     = q_line_ext;
                    lo_next       = '0;
                    hi_next       = line_total;
                    best_next     = '0;
                    kind_next     = cmd.is_line ? sli_pkg::KIND_LINE : sli_pkg::KIND_POS;
                    found_next    = line_ok;
                    has_next_next = line_has_next;
                end
            end
            sli_pkg::LK_SRCH_RD: begin
                mid_next = mid_full[ADDR_BITS-1:0];
                rd_addr  = mid_full[ADDR_BITS-1:0];
            end
            sli_pkg::LK_SRCH_CMP: begin
                if (ram_start <= offset_reg) begin
                    lo_next   = LINE_BITS'(mid_reg) + LINE_BITS'(1);
                    best_next = ram_start;
                end else begin
                    hi_next = LINE_BITS'(mid_reg);
                end
            end
            sli_pkg::LK_LINE_RD_START: begin
                rd_addr = line_m1[ADDR_BITS-1:0];
            end
            sli_pkg::LK_LINE_RD_NEXT: begin
                start_next = ram_start;
                rd_addr    = line_reg[ADDR_BITS-1:0];
            end
            sli_pkg::LK_LINE_CALC: begin
                // Trim one carriage return; a CR implies the line is nonempty
                len_next = (end_off > start_reg) ?
                           (end_off - start_reg - OFFSET_BITS'(end_cr)) : '0;
            end
            sli_pkg::LK_RESULT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = kind_reg;
                    if (kind_reg == sli_pkg::KIND_LINE) begin
                        m_tdata_next = OUT_W'({overflow, found_reg,
                                               found_reg ? len_reg : OFFSET_BITS'(0),
                                               found_reg ? start_reg : OFFSET_BITS'(0),
                                               (OFFSET_BITS + 1)'(0),
                                               LINE_BITS'(0)});
                    end else begin
                        m_tdata_next = OUT_W'({overflow, 1'b0,
                                               OFFSET_BITS'(0), OFFSET_BITS'(0),
                                               column, lo_reg});
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sli_pkg::LK_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        offset_reg   <= offset_next;
        line_reg     <= line_next;
        best_reg     <= best_next;
        start_reg    <= start_next;
        len_reg      <= len_next;
        kind_reg     <= kind_next;
        found_reg    <= found_next;
        has_next_reg <= has_next_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign busy     = state_reg != sli_pkg::LK_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_cmp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sli_pkg::LK_SRCH_CMP) |-> (lo_reg < hi_reg) &&
        (LINE_BITS'(mid_reg) >= lo_reg) && (LINE_BITS'(mid_reg) < hi_reg))
        else $error("search midpoint outside the open range");

    a_hi_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sli_pkg::LK_SRCH_RD) |-> (hi_reg <= line_total))
        else $error("search upper bound beyond the line count");

    a_line_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sli_pkg::LK_LINE_RD_START) |-> found_reg &&
        (kind_reg == sli_pkg::KIND_LINE))
        else $error("line fetch started for a line that does not exist");

    a_load_from_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !$past(m_tvalid_reg)) |-> ($past(state_reg) == sli_pkg::LK_RESULT))
        else $error("output register loaded outside the result state");

endmodule
`default_nettype wire

// ----- rtl/source_line_index_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// source_line_index_top: line start index with offset and line lookups
// Builds a line start table in RAM from a text stream and answers queries.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel: s_tuser carries the request (start, byte, offset query,
//   line query); s_tdata carries the byte, the offset and the line number.
//   m_ channel: one transfer per query; m_tuser is the result kind, m_tdata
//   the position or the line extent plus found and the sticky overflow flag.
//   Start and byte transfers produce no result, so text streams at one byte
//   per cycle while no query is running; a newline writes the next line
//   start through the RAM write port in the same cycle as its transfer.
//   An offset query binary-searches the RAM: each step is one read plus a
//   compare, repeated until the search range is empty.
//   A line query makes two dependent RAM reads and the length calculation;
//   when the line does not exist it goes straight to the result.
//   The result is held in an output register; while the receiver stalls,
//   start and byte transfers are still taken, and a further query runs up
//   to its answer and then waits for the register to drain.
//   Reset leaves a line count of one, length zero and overflow clear;
//   the RAM is not cleared, and a start request is expected before queries.
// ---------------------------------------------------------------------------
module source_line_index_top #(
    parameter int MAX_LINES   = sli_pkg::MAX_LINES_DEF,
    parameter int OFFSET_BITS = sli_pkg::OFFSET_BITS_DEF,
    localparam int LINE_BITS  = $clog2(MAX_LINES + 1),
    localparam int IN_FIELDS  = sli_pkg::BYTE_BITS + OFFSET_BITS + sli_pkg::QUERY_LINE_BITS,
    localparam int IN_W       = ((IN_FIELDS + 7) / 8) * 8,
    localparam int OUT_FIELDS = LINE_BITS + 3 * OFFSET_BITS + 3,
    localparam int OUT_W      = ((OUT_FIELDS + 7) / 8) * 8
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // source_byte, query_offset, query_line
    input  wire logic [IN_W-1:0]              s_tdata,
    // req_type
    input  wire logic [sli_pkg::REQ_BITS-1:0] s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // line_number, column_number, line_start, line_length, found, overflow
    output logic      [OUT_W-1:0]             m_tdata,
    // result_kind
    output logic                              m_tuser
);

    localparam int ADDR_BITS = $clog2(MAX_LINES);
    localparam int ENTRY_W   = OFFSET_BITS + 1;
    localparam int OFF_LO    = sli_pkg::BYTE_BITS;
    localparam int LINE_LO   = sli_pkg::BYTE_BITS + OFFSET_BITS;

    logic [LINE_BITS-1:0]   line_total_reg, line_total_next;
    logic [OFFSET_BITS-1:0] length_reg, length_next;
    logic                   prev_cr_reg, prev_cr_next;
    logic                   overflow_reg, overflow_next;

    logic                   accept;
    sli_pkg::req_t          req;
    logic [sli_pkg::BYTE_BITS-1:0]       in_byte;
    logic [OFFSET_BITS-1:0]              in_offset;
    logic [sli_pkg::QUERY_LINE_BITS-1:0] in_line;
    logic [OFFSET_BITS-1:0] length_inc;
    logic                   busy;
    sli_pkg::lk_cmd_t       cmd;

    logic                   wr_en;
    logic [ADDR_BITS-1:0]   wr_addr;
    logic [ENTRY_W-1:0]     wr_data;
    logic [ADDR_BITS-1:0]   rd_addr;
    logic [ENTRY_W-1:0]     rd_data;

    assign s_tready  = !busy;
    assign accept    = s_tvalid && s_tready;
    assign req       = sli_pkg::req_t'(s_tuser);
    assign in_byte   = s_tdata[sli_pkg::BYTE_BITS-1:0];
    assign in_offset = s_tdata[OFF_LO +: OFFSET_BITS];
    assign in_line   = s_tdata[LINE_LO +: sli_pkg::QUERY_LINE_BITS];

    assign cmd.go      = accept && ((req == sli_pkg::REQ_OFFSET) || (req == sli_pkg::REQ_LINE));
    assign cmd.is_line = req == sli_pkg::REQ_LINE;

    // Saturate the length at its top value
    assign length_inc = (length_reg != '1) ? length_reg + OFFSET_BITS'(1) : length_reg;

    // Table builder: each entry holds a line start and the CR flag of the line before
    always_comb begin
        line_total_next = line_total_reg;
        length_next     = length_reg;
        prev_cr_next    = prev_cr_reg;
        overflow_next   = overflow_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        if (accept) begin
            case (req)
                sli_pkg::REQ_START: begin
                    line_total_next = LINE_BITS'(1);
                    length_next     = '0;
                    prev_cr_next    = 1'b0;
                    overflow_next   = 1'b0;
                    wr_en           = 1'b1;
                end
                sli_pkg::REQ_BYTE: begin
                    length_next  = length_inc;
                    prev_cr_next = in_byte == sli_pkg::CR_BYTE;
                    if (in_byte == sli_pkg::NL_BYTE) begin
                        if (line_total_reg == LINE_BITS'(MAX_LINES)) begin
                            overflow_next = 1'b1;
                        end else begin
                            wr_en           = 1'b1;
                            wr_addr         = line_total_reg[ADDR_BITS-1:0];
                            wr_data         = {prev_cr_reg, length_inc};
                            line_total_next = line_total_reg + LINE_BITS'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_total_reg <= LINE_BITS'(1);
            length_reg     <= '0;
            prev_cr_reg    <= 1'b0;
            overflow_reg   <= 1'b0;
        end else begin
            line_total_reg <= line_total_next;
            length_reg     <= length_next;
            prev_cr_reg    <= prev_cr_next;
            overflow_reg   <= overflow_next;
        end
    end

    sli_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_LINES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sli_lookup #(
        .MAX_LINES   (MAX_LINES),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_lookup (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .query_offset  (in_offset),
        .query_line    (in_line),
        .line_total    (line_total_reg),
        .text_length   (length_reg),
        .prev_cr       (prev_cr_reg),
        .overflow      (overflow_reg),
        .busy          (busy),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

    a_total_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (line_total_reg != '0) && (line_total_reg <= LINE_BITS'(MAX_LINES)))
        else $error("line count out of range");

    a_no_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !wr_en)
        else $error("table written while a lookup is running");

endmodule
`default_nettype wire

// ----- test/source_line_index_top_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// source_line_index_top_tb: self-checking bench for the source line index
// Streams text and queries into the block and mirrors the line table in
// the bench. Offset and line answers are compared against that mirror, or
// against a typed-in value for the obvious directed rows. Random frames mix
// text, CR/LF endings and queries. One long frame fills the table past
// overflow. Both handshake sides idle at random.
// ---------------------------------------------------------------------------
module source_line_index_top_tb;

    localparam int TAB_DEPTH   = sli_pkg::MAX_LINES_DEF;
    localparam int RAND_ITEMS  = 1650;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 40;

    // One answer of the block, fields in output order
    typedef struct packed {
        logic        kind;
        logic [10:0] ln;
        logic [20:0] col;
        logic [19:0] lstart;
        logic [19:0] llen;
        logic        found;
        logic        ovf;
    } idx_result_t;

    typedef struct {
        sli_pkg::req_t rq;
        logic [7:0]    sbyte;
        logic [19:0]   offs;
        logic [11:0]   qline;
        bit            typed;
        idx_result_t   res;
    } dir_row_t;

    localparam idx_result_t LINE_MISSING =
        '{sli_pkg::KIND_LINE, 11'd0, 21'd0, 20'd0, 20'd0, 1'b0, 1'b0};
    localparam idx_result_t NO_ANSWER = '0;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [39:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [79:0] m_tdata;
    wire         m_tuser;

    source_line_index_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Mirror of the line table
    logic [19:0] start_mirror [0:TAB_DEPTH-1];
    bit          cr_mirror    [0:TAB_DEPTH-1];
    int unsigned lines_held = 1;
    logic [19:0] text_len   = '0;
    bit          last_was_cr;
    bit          table_full_seen;

    idx_result_t answers_due [$];
    dir_row_t    dir_tab     [$];

    int  mismatch_cnt   = 0;
    int  answers_seen   = 0;
    int  ovf_answers    = 0;
    int  sent_total     = 0;
    int  idle_cycles    = 0;
    bit  calm           = 1'b0;

    // Advance the mirror by one request; return 1 with the answer for queries
    function automatic bit line_index_apply(input sli_pkg::req_t rq, input logic [7:0] b,
                                            input logic [19:0] o, input logic [11:0] l,
                                            output idx_result_t r);
        int unsigned lo, hi, mid, st, en, nx, len;
        bit          cr;
        r = '0;
        case (rq)
            sli_pkg::REQ_START: begin
                start_mirror[0] = '0;
                lines_held      = 1;
                text_len        = '0;
                last_was_cr     = 1'b0;
                table_full_seen = 1'b0;
                return 1'b0;
            end
            sli_pkg::REQ_BYTE: begin
                if (text_len != '1)
                    text_len = text_len + 1'b1;
                if (b == sli_pkg::NL_BYTE) begin
                    if (lines_held >= TAB_DEPTH) begin
                        table_full_seen = 1'b1;
                    end else begin
                        cr_mirror[lines_held-1] = last_was_cr;
                        start_mirror[lines_held] = text_len;
                        lines_held++;
                    end
                end
                last_was_cr = (b == sli_pkg::CR_BYTE);
                return 1'b0;
            end
            sli_pkg::REQ_OFFSET: begin
                lo = 0;
                hi = lines_held;
                while (lo < hi) begin
                    mid = (lo + hi) / 2;
                    if (start_mirror[mid] <= o)
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                r.kind = sli_pkg::KIND_POS;
                r.ln   = 11'(lo);
                r.col  = (lo > 0) ? 21'(o - start_mirror[lo-1] + 1) : 21'd1;
            end
            default: begin
                r.kind = sli_pkg::KIND_LINE;
                if (l != 0 && l <= lines_held) begin
                    st = start_mirror[l-1];
                    if (l < lines_held) begin
                        nx = start_mirror[l];
                        en = (nx > 0) ? nx - 1 : 0;
                        cr = cr_mirror[l-1];
                    end else begin
                        en = text_len;
                        cr = last_was_cr;
                    end
                    len = (en > st) ? en - st : 0;
                    if (len > 0 && cr)
                        len--;
                    r.lstart = 20'(st);
                    r.llen   = 20'(len);
                    r.found  = 1'b1;
                end
            end
        endcase
        r.ovf = table_full_seen;
        return 1'b1;
    endfunction

    task automatic send_req(input sli_pkg::req_t rq, input logic [7:0] b,
                            input logic [19:0] o, input logic [11:0] l, input bit typed,
                            input idx_result_t typed_res);
        idx_result_t r;
        bit          has;
        while (!calm && $urandom_range(99) < 30) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq;
        s_tdata  <= {l, o, b};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        has = line_index_apply(rq, b, o, l, r);
        if (has)
            answers_due.push_back(typed ? typed_res : r);
        sent_total++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_req(sli_pkg::REQ_BYTE, b, 20'($urandom), 12'($urandom), 1'b0, NO_ANSWER);
    endtask

    // Mostly aim at valid offsets and lines, now and then anywhere in range
    task automatic random_query();
        logic [19:0] o;
        logic [11:0] l;
        o = ($urandom_range(4) == 0) ? 20'($urandom) : 20'($urandom_range(text_len + 3));
        l = ($urandom_range(4) == 0) ? 12'($urandom) : 12'($urandom_range(lines_held + 1));
        send_req($urandom_range(1) ? sli_pkg::REQ_OFFSET : sli_pkg::REQ_LINE,
                 8'($urandom), o, l, 1'b0, NO_ANSWER);
    endtask

    task automatic wait_drained();
        if (answers_due.size() != 0) begin
            s_tvalid <= 1'b0;
            while (answers_due.size() != 0)
                @(posedge aclk);
        end
    endtask

    // Receiver side
    always @(posedge aclk)
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 30);

    // Result checking
    always @(posedge aclk) begin
        idx_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[10:0], m_tdata[31:11], m_tdata[51:32],
                   m_tdata[71:52], m_tdata[72], m_tdata[73]};
            answers_seen++;
            if (got.ovf)
                ovf_answers++;
            if (answers_due.size() == 0) begin
                $error("result transfer with no answer pending");
                mismatch_cnt++;
            end else begin
                want = answers_due.pop_front();
                if (got != want) begin
                    mismatch_cnt++;
                    if (got.kind != want.kind)
                        $error("result_kind: expected %0d, got %0d", want.kind, got.kind);
                    if (got.ln != want.ln)
                        $error("line_number: expected %0d, got %0d", want.ln, got.ln);
                    if (got.col != want.col)
                        $error("column_number: expected %0d, got %0d", want.col, got.col);
                    if (got.lstart != want.lstart)
                        $error("line_start: expected %0d, got %0d", want.lstart, got.lstart);
                    if (got.llen != want.llen)
                        $error("line_length: expected %0d, got %0d", want.llen, got.llen);
                    if (got.found != want.found)
                        $error("found: expected %0d, got %0d", want.found, got.found);
                    if (got.ovf != want.ovf)
                        $error("overflow: expected %0d, got %0d", want.ovf, got.ovf);
                end
            end
        end
    end

    // Watchdog: count cycles with no transfer on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int  k, extra, p;
        bit  flood_done;
        dir_row_t row;

        // Directed rows: queries on the empty text, then bytes and queries across CR/LF endings
        dir_tab.push_back(dir_row_t'{sli_pkg::REQ_START,  8'h00, 20'd0, 12'd0, 1'b0,
                                     NO_ANSWER});
        dir_tab.push_back(dir_row_t'{sli_pkg::REQ_OFFSET, 8'h00, 20'd0, 12'd0, 1'b1,
                          '{sli_pkg::KIND_POS, 11'd1, 21'd1, 20'd0, 20'd0, 1'b0, 1'b0}});
        dir_tab.push_back(dir_row_t'{sli_pkg::REQ_LINE,   8'h00, 20'd0, 12'd1, 1'b1,
                          '{sli_pkg::KIND_LINE, 11'd0, 21'd0, 20'd0, 20'd0, 1'b1, 1'b0}});
        dir_tab.push_back(dir_row_t'{sli_pkg::REQ_LINE,   8'h00, 20'd0, 12'd0, 1'b1,
                                     LINE_MISSING});
        dir_tab.push_back(dir_row_t'{sli_pkg::REQ_LINE,   8'hFF, 20'd0, 12'hFFF, 1'b1,
                                     LINE_MISSING});
        dir_tab.push_back(dir_row_t'{sli_pkg::REQ_OFFSET, 8'h00, 20'hFFFFF, 12'd0, 1'b1,
                          '{sli_pkg::KIND_POS, 11'd1, 21'h100000, 20'd0, 20'd0, 1'b0, 1'b0}});
        dir_tab.push_back(dir_row_t'{sli_pkg::REQ_BYTE,   8'h61, 20'd0, 12'd0, 1'b0,
                                     NO_ANSWER});
        dir_tab.push_back(dir_row_t'{sli_pkg::REQ_BYTE,   sli_pkg::CR_BYTE, 20'd0, 12'd0,
                                     1'b0, NO_ANSWER});
        dir_tab.push_back(dir_row_t'{sli_pkg::REQ_BYTE,   sli_pkg::NL_BYTE, 20'd0, 12'd0,
                                     1'b0, NO_ANSWER});
        dir_tab.push_back(dir_row_t'{sli_pkg::REQ_BYTE,   8'hFF, 20'hFFFFF, 12'hFFF, 1'b0,
                                     NO_ANSWER});
        dir_tab.push_back(dir_row_t'{sli_pkg::REQ_BYTE,   8'h00, 20'd0, 12'd0, 1'b0,
                                     NO_ANSWER});
        dir_tab.push_back(dir_row_t'{sli_pkg::REQ_BYTE,   sli_pkg::CR_BYTE, 20'd0, 12'd0,
                                     1'b0, NO_ANSWER});
        dir_tab.push_back(dir_row_t'{sli_pkg::REQ_LINE,   8'h00, 20'd0, 12'd1, 1'b0,
                                     NO_ANSWER});
        dir_tab.push_back(dir_row_t'{sli_pkg::REQ_LINE,   8'h00, 20'd0, 12'd2, 1'b0,
                                     NO_ANSWER});
        dir_tab.push_back(dir_row_t'{sli_pkg::REQ_OFFSET, 8'h00, 20'd2, 12'd0, 1'b0,
                                     NO_ANSWER});
        dir_tab.push_back(dir_row_t'{sli_pkg::REQ_OFFSET, 8'h00, 20'hFFFFF, 12'd0, 1'b0,
                                     NO_ANSWER});
        dir_tab.push_back(dir_row_t'{sli_pkg::REQ_BYTE,   sli_pkg::NL_BYTE, 20'd0, 12'd0,
                                     1'b0, NO_ANSWER});
        dir_tab.push_back(dir_row_t'{sli_pkg::REQ_BYTE,   sli_pkg::NL_BYTE, 20'd0, 12'd0,
                                     1'b0, NO_ANSWER});
        dir_tab.push_back(dir_row_t'{sli_pkg::REQ_BYTE,   sli_pkg::CR_BYTE, 20'd0, 12'd0,
                                     1'b0, NO_ANSWER});
        dir_tab.push_back(dir_row_t'{sli_pkg::REQ_BYTE,   8'h78, 20'd0, 12'd0, 1'b0,
                                     NO_ANSWER});
        dir_tab.push_back(dir_row_t'{sli_pkg::REQ_BYTE,   sli_pkg::NL_BYTE, 20'd0, 12'd0,
                                     1'b0, NO_ANSWER});
        dir_tab.push_back(dir_row_t'{sli_pkg::REQ_LINE,   8'h00, 20'd0, 12'd3, 1'b0,
                                     NO_ANSWER});
        dir_tab.push_back(dir_row_t'{sli_pkg::REQ_LINE,   8'h00, 20'd0, 12'd4, 1'b0,
                                     NO_ANSWER});
        dir_tab.push_back(dir_row_t'{sli_pkg::REQ_LINE,   8'h00, 20'd0, 12'd6, 1'b1,
                                     LINE_MISSING});
        dir_tab.push_back(dir_row_t'{sli_pkg::REQ_OFFSET, 8'h00, 20'd8, 12'd0, 1'b0,
                                     NO_ANSWER});
        dir_tab.push_back(dir_row_t'{sli_pkg::REQ_START,  8'h00, 20'd0, 12'd0, 1'b0,
                                     NO_ANSWER});
        dir_tab.push_back(dir_row_t'{sli_pkg::REQ_LINE,   8'h00, 20'd0, 12'd2, 1'b1,
                                     LINE_MISSING});

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) begin
            row = dir_tab[i];
            send_req(row.rq, row.sbyte, row.offs, row.qline, row.typed, row.res);
        end

        // Hold the sender until every directed answer is back
        wait_drained();

        flood_done = 1'b0;
        while (sent_total < RAND_ITEMS) begin
            calm = (sent_total > 150 && sent_total < 400);
            if (!flood_done && sent_total > 400) begin
                // Fill the table and keep going past it
                calm = 1'b0;
                wait_drained();
                send_req(sli_pkg::REQ_START, 8'($urandom), 20'($urandom), 12'($urandom),
                         1'b0, NO_ANSWER);
                extra = 0;
                while (lines_held < TAB_DEPTH || extra < 6) begin
                    if (lines_held >= TAB_DEPTH)
                        extra++;
                    if ($urandom_range(9) == 0)
                        send_byte(sli_pkg::CR_BYTE);
                    send_byte(sli_pkg::NL_BYTE);
                    if ($urandom_range(39) == 0)
                        random_query();
                end
                send_req(sli_pkg::REQ_LINE, 8'd0, 20'd0, 12'(TAB_DEPTH), 1'b0, NO_ANSWER);
                send_req(sli_pkg::REQ_LINE, 8'd0, 20'd0, 12'(TAB_DEPTH + 1), 1'b0,
                         NO_ANSWER);
                send_req(sli_pkg::REQ_OFFSET, 8'd0, 20'hFFFFF, 12'd0, 1'b0, NO_ANSWER);
                send_req(sli_pkg::REQ_OFFSET, 8'd0, 20'(text_len - 1), 12'd0, 1'b0,
                         NO_ANSWER);
                send_byte(8'h41);
                repeat (12) random_query();
                flood_done = 1'b1;
            end
            send_req(sli_pkg::REQ_START, 8'($urandom), 20'($urandom), 12'($urandom), 1'b0,
                     NO_ANSWER);
            k = $urandom_range(60, 5);
            repeat (k) begin
                p = $urandom_range(99);
                if (p < 5) begin
                    // noise: any request with any fields, a stray start included
                    send_req(sli_pkg::req_t'($urandom_range(3)), 8'($urandom),
                             20'($urandom), 12'($urandom), 1'b0, NO_ANSWER);
                end else if (p < 65) begin
                    p = $urandom_range(99);
                    if (p < 15) begin
                        send_byte(sli_pkg::NL_BYTE);
                    end else if (p < 23) begin
                        send_byte(sli_pkg::CR_BYTE);
                    end else if (p < 28) begin
                        send_byte(sli_pkg::CR_BYTE);
                        send_byte(sli_pkg::NL_BYTE);
                    end else begin
                        send_byte(8'($urandom));
                    end
                end else begin
                    random_query();
                end
            end
        end

        s_tvalid <= 1'b0;
        calm = 1'b0;
        while (answers_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("sent %0d requests, checked %0d answers (%0d with overflow set)",
                 sent_total, answers_seen, ovf_answers);
        $display("covered CR/LF line ends, out-of-range lines and offsets, table overflow");
        if (mismatch_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- source_line_index_top.f -----
rtl/sli_pkg.sv
rtl/sli_ram.sv
rtl/sli_lookup.sv
rtl/source_line_index_top.sv
test/source_line_index_top_tb.sv
